// ===== rtl/encap_header_http_method_parser_assert.svh =====
// Assertion macros used by the parser RTL. Each use checks on the rising edge
// of clk and is disabled while rst_n is low.
`ifndef ENCAP_HEADER_HTTP_METHOD_PARSER_ASSERT_SVH
`define ENCAP_HEADER_HTTP_METHOD_PARSER_ASSERT_SVH

// Same-cycle implication.
`define EHHMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ehhmp assertion failed");

// Next-cycle implication.
`define EHHMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ehhmp assertion failed");

`endif

// ===== rtl/ehhmp_pkg.sv =====
`timescale 1ns / 1ps

package ehhmp_pkg;

  localparam int FRAME_MAX_LEN = 2048;
  localparam int CNT_W = $clog2(FRAME_MAX_LEN);
  // offsets run past the capture limit by up to two header lengths
  localparam int OFS_W = CNT_W + 2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_MAX_LEN - 1);

  localparam logic [OFS_W-1:0] OFS_ETH_TYPE = OFS_W'(12);
  localparam logic [OFS_W-1:0] OFS_ETH_TYPE_LO = OFS_W'(13);
  localparam logic [OFS_W-1:0] OFS_IP_PLAIN = OFS_W'(14);
  localparam logic [OFS_W-1:0] OFS_TAG_TYPE = OFS_W'(16);
  localparam logic [OFS_W-1:0] OFS_TAG_TYPE_LO = OFS_W'(17);
  localparam logic [OFS_W-1:0] OFS_IP_TAGGED = OFS_W'(18);
  localparam logic [OFS_W-1:0] OFS_IP_PPPOE = OFS_W'(26);
  localparam logic [OFS_W-1:0] OFS_IP_PROTO = OFS_W'(9);
  localparam logic [OFS_W-1:0] OFS_UDP_LEN = OFS_W'(8);
  localparam logic [OFS_W-1:0] OFS_GTP_SHORT = OFS_W'(8);
  localparam logic [OFS_W-1:0] OFS_GTP_LONG = OFS_W'(12);
  localparam logic [OFS_W-1:0] OFS_TCP_DOFF = OFS_W'(12);

  localparam logic [7:0] BYTE_ETH_IPV4_HI = 8'h08;
  localparam logic [7:0] BYTE_ETH_VLAN_HI = 8'h81;
  localparam logic [7:0] BYTE_ETH_LO = 8'h00;
  localparam logic [7:0] BYTE_PPPOE_HI = 8'h88;
  localparam logic [7:0] BYTE_PPPOE_LO = 8'h64;
  localparam logic [7:0] BYTE_PROTO_UDP = 8'h11;
  localparam logic [7:0] BYTE_GTP_SHORT = 8'h30;
  localparam logic [7:0] BYTE_GTP_LONG = 8'h32;

  localparam logic [1:0] MATCH_GET = 2'b01;
  localparam logic [1:0] MATCH_POST = 2'b10;
  localparam logic [1:0] MATCH_BOTH = 2'b11;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ETH_HI    = 4'd1,
    PH_ETH_LO    = 4'd2,
    PH_TAG_HI    = 4'd3,
    PH_TAG_LO    = 4'd4,
    PH_IP_IHL    = 4'd5,
    PH_IP_PROTO  = 4'd6,
    PH_GTP       = 4'd7,
    PH_INNER_IHL = 4'd8,
    PH_TCP_DOFF  = 4'd9,
    PH_METHOD    = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    VD_GET       = 3'd0,
    VD_POST      = 3'd1,
    VD_BAD_ETH   = 3'd2,
    VD_BAD_TAG   = 3'd3,
    VD_OTHER     = 3'd4,
    VD_TRUNCATED = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [OFS_W-1:0] next_ofs;
    phase_t           phase;
    logic [5:0]       held;
    logic [OFS_W-1:0] ip_ofs;
    logic [OFS_W-1:0] tcp_ofs;
    logic [1:0]       match;
    logic             verdict_done;
  } walk_state_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] target_offset;
    logic [7:0] ip_offset;
    logic [7:0] tcp_offset;
  } walk_result_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [OFS_W-1:0] ofs_max(input logic [OFS_W-1:0] a,
                                               input logic [OFS_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/ehhmp_chan_if.sv =====
`timescale 1ns / 1ps

interface ehhmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_start,
                  output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_start,
                input frame_end, output ready);
endinterface

interface ehhmp_out_if;
  logic                valid;
  logic                ready;
  ehhmp_pkg::verdict_t verdict;
  logic [7:0]          target_offset;
  logic [7:0]          ip_offset;
  logic [7:0]          tcp_offset;

  modport source (output valid, output verdict, output target_offset,
                  output ip_offset, output tcp_offset, input ready);
  modport sink (input valid, input verdict, input target_offset,
                input ip_offset, input tcp_offset, output ready);
endinterface

// ===== rtl/encap_header_http_method_parser.sv =====
`timescale 1ns / 1ps

// Frame header walker with an HTTP method test.
// in_ch carries frame bytes in wire order, one per transfer, with
// frame_start on the first byte and frame_end on the last. out_ch carries
// one verdict per frame (GET, POST, bad ethertype, bad tagged type, other
// method, truncated) with the request target offset and the IPv4 and TCP
// header offsets found so far. Bytes outside a frame and bytes after the
// verdict give no transfer on out_ch.
// Path: the byte that decides a verdict passes the input register, then the
// result register, from which the verdict leaves on out_ch.
// Throughput: one byte per cycle unless a verdict byte holds (see Stall);
// all header decisions for a byte, even when several fields start on that
// byte, are made in one pass of the step logic between the two registers.
// Reset (rst_n low, synchronous): both registers empty, the walker waits
// for a frame start.
// Stall: while a verdict waits on out_ch, bytes that decide nothing keep
// flowing; a byte that would produce a second verdict holds in the input
// register until the first one is taken.
`include "encap_header_http_method_parser_assert.svh"

module encap_header_http_method_parser (
  input  logic            clk,
  input  logic            rst_n,
  ehhmp_in_if.sink        in_ch,
  ehhmp_out_if.source     out_ch
);

  // input register
  logic       s_valid_r;
  logic       s_valid_nxt;
  logic [7:0] s_byte_r;
  logic       s_start_r;
  logic       s_end_r;

  // walker state
  ehhmp_pkg::walk_state_t st_r;
  ehhmp_pkg::walk_state_t st_nxt;

  // result register
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  ehhmp_pkg::walk_result_t out_res_r;
  ehhmp_pkg::walk_result_t step_res;

  logic step_hit;
  logic s_adv;
  logic in_xfer;

  ehhmp_step u_step (
    .st_i        (st_r),
    .frame_byte  (s_byte_r),
    .frame_start (s_start_r),
    .frame_end   (s_end_r),
    .st_o        (st_nxt),
    .hit_o       (step_hit),
    .res_o       (step_res)
  );

  // Advance the held byte unless it carries a verdict and the result
  // register is still occupied.
  assign s_adv = s_valid_r && (!step_hit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s_valid_r || s_adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_xfer) begin
      s_valid_nxt = 1'b1;
    end else if (s_adv) begin
      s_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s_adv && step_hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.byte_count <= '0;
      st_r.next_ofs <= '0;
      st_r.phase <= ehhmp_pkg::PH_IDLE;
      st_r.held <= '0;
      st_r.ip_ofs <= '0;
      st_r.tcp_ofs <= '0;
      st_r.match <= ehhmp_pkg::MATCH_BOTH;
      st_r.verdict_done <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // update the walker only when the held byte moves on
      if (s_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload: capture on transfer, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_byte_r <= in_ch.frame_byte;
      s_start_r <= in_ch.frame_start;
      s_end_r <= in_ch.frame_end;
    end
    if (s_adv && step_hit) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.verdict = out_res_r.verdict;
  assign out_ch.target_offset = out_res_r.target_offset;
  assign out_ch.ip_offset = out_res_r.ip_offset;
  assign out_ch.tcp_offset = out_res_r.tcp_offset;

  `EHHMP_ASSERT_NEXT(a_hit_loads_out, s_adv && step_hit, out_valid_r)
  `EHHMP_ASSERT_NEXT(a_hit_ends_walk, s_adv && step_hit,
    st_r.phase == ehhmp_pkg::PH_DONE || st_r.phase == ehhmp_pkg::PH_IDLE)
  `EHHMP_ASSERT_NOW(a_done_has_verdict, st_r.phase == ehhmp_pkg::PH_DONE,
    st_r.verdict_done)
  `EHHMP_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ch.ready)
  `EHHMP_ASSERT_NOW(a_target_only_method, out_valid_r &&
    out_res_r.verdict != ehhmp_pkg::VD_GET && out_res_r.verdict != ehhmp_pkg::VD_POST,
    out_res_r.target_offset == 8'd0)

endmodule

// ===== rtl/ehhmp_step.sv =====
`timescale 1ns / 1ps

module ehhmp_step (
  input  ehhmp_pkg::walk_state_t  st_i,
  input  logic [7:0]              frame_byte,
  input  logic                    frame_start,
  input  logic                    frame_end,
  output ehhmp_pkg::walk_state_t  st_o,
  output logic                    hit_o,
  output ehhmp_pkg::walk_result_t res_o
);

  ehhmp_pkg::walk_state_t st;
  logic                   hit;
  logic                   active;
  logic                   last;
  logic [ehhmp_pkg::OFS_W-1:0] pos;
  logic [1:0]             m;
  logic [1:0]             idx;

  always_comb begin
    st = st_i;
    hit = 1'b0;
    res_o.verdict = ehhmp_pkg::VD_TRUNCATED;
    res_o.target_offset = '0;
    m = '0;
    idx = '0;

    if (frame_start) begin
      st.byte_count = '0;
      st.next_ofs = ehhmp_pkg::OFS_ETH_TYPE;
      st.phase = ehhmp_pkg::PH_ETH_HI;
      st.held = '0;
      st.ip_ofs = '0;
      st.tcp_ofs = '0;
      st.match = ehhmp_pkg::MATCH_BOTH;
      st.verdict_done = 1'b0;
    end

    pos = ehhmp_pkg::OFS_W'(st.byte_count);
    last = (st.byte_count == ehhmp_pkg::CNT_LAST);
    active = (st.phase != ehhmp_pkg::PH_IDLE) && (st.phase != ehhmp_pkg::PH_DONE);

    if (st.phase == ehhmp_pkg::PH_DONE && frame_end) begin
      st.phase = ehhmp_pkg::PH_IDLE;
    end

    if (active) begin
      // several fields may start on one byte: UDP into GTP into the inner
      // header, or the TCP offset into the first method byte
      for (int i = 0; i < 3; i++) begin
        if (!hit && st.phase != ehhmp_pkg::PH_DONE && pos == st.next_ofs) begin
          case (st.phase)
            ehhmp_pkg::PH_ETH_HI: begin
              st.held = frame_byte[5:0];
              st.match[0] = (frame_byte == ehhmp_pkg::BYTE_ETH_IPV4_HI);
              st.match[1] = (frame_byte == ehhmp_pkg::BYTE_ETH_VLAN_HI);
              st.next_ofs = ehhmp_pkg::OFS_ETH_TYPE_LO;
              st.phase = ehhmp_pkg::PH_ETH_LO;
            end
            ehhmp_pkg::PH_ETH_LO: begin
              if (st.match[0] && frame_byte == ehhmp_pkg::BYTE_ETH_LO) begin
                st.ip_ofs = ehhmp_pkg::OFS_IP_PLAIN;
                st.next_ofs = ehhmp_pkg::OFS_IP_PLAIN;
                st.phase = ehhmp_pkg::PH_IP_IHL;
              end else if (st.match[1] && frame_byte == ehhmp_pkg::BYTE_ETH_LO) begin
                st.next_ofs = ehhmp_pkg::OFS_TAG_TYPE;
                st.phase = ehhmp_pkg::PH_TAG_HI;
              end else begin
                hit = 1'b1;
                res_o.verdict = ehhmp_pkg::VD_BAD_ETH;
              end
              st.match = ehhmp_pkg::MATCH_BOTH;
            end
            ehhmp_pkg::PH_TAG_HI: begin
              st.match[0] = (frame_byte == ehhmp_pkg::BYTE_PPPOE_HI);
              st.match[1] = (frame_byte == ehhmp_pkg::BYTE_ETH_IPV4_HI);
              st.next_ofs = ehhmp_pkg::OFS_TAG_TYPE_LO;
              st.phase = ehhmp_pkg::PH_TAG_LO;
            end
            ehhmp_pkg::PH_TAG_LO: begin
              if (st.match[0] && frame_byte == ehhmp_pkg::BYTE_PPPOE_LO) begin
                st.ip_ofs = ehhmp_pkg::OFS_IP_PPPOE;
                st.next_ofs = ehhmp_pkg::OFS_IP_PPPOE;
                st.phase = ehhmp_pkg::PH_IP_IHL;
              end else if (st.match[1] && frame_byte == ehhmp_pkg::BYTE_ETH_LO) begin
                st.ip_ofs = ehhmp_pkg::OFS_IP_TAGGED;
                st.next_ofs = ehhmp_pkg::OFS_IP_TAGGED;
                st.phase = ehhmp_pkg::PH_IP_IHL;
              end else begin
                hit = 1'b1;
                res_o.verdict = ehhmp_pkg::VD_BAD_TAG;
              end
              st.match = ehhmp_pkg::MATCH_BOTH;
            end
            ehhmp_pkg::PH_IP_IHL: begin
              st.held = {frame_byte[3:0], 2'b00};
              st.next_ofs = st.ip_ofs + ehhmp_pkg::OFS_IP_PROTO;
              st.phase = ehhmp_pkg::PH_IP_PROTO;
            end
            ehhmp_pkg::PH_IP_PROTO: begin
              if (frame_byte == ehhmp_pkg::BYTE_PROTO_UDP) begin
                st.next_ofs = ehhmp_pkg::ofs_max(
                  st.ip_ofs + ehhmp_pkg::OFS_W'(st.held) + ehhmp_pkg::OFS_UDP_LEN, pos);
                st.phase = ehhmp_pkg::PH_GTP;
              end else begin
                st.tcp_ofs = st.ip_ofs + ehhmp_pkg::OFS_W'(st.held);
                st.next_ofs = st.ip_ofs + ehhmp_pkg::OFS_W'(st.held)
                              + ehhmp_pkg::OFS_TCP_DOFF;
                st.phase = ehhmp_pkg::PH_TCP_DOFF;
              end
            end
            ehhmp_pkg::PH_GTP: begin
              if (frame_byte == ehhmp_pkg::BYTE_GTP_SHORT) begin
                st.next_ofs = pos + ehhmp_pkg::OFS_GTP_SHORT;
              end else if (frame_byte == ehhmp_pkg::BYTE_GTP_LONG) begin
                st.next_ofs = pos + ehhmp_pkg::OFS_GTP_LONG;
              end else begin
                st.next_ofs = pos;
              end
              st.phase = ehhmp_pkg::PH_INNER_IHL;
            end
            ehhmp_pkg::PH_INNER_IHL: begin
              st.ip_ofs = pos;
              st.tcp_ofs = pos + ehhmp_pkg::OFS_W'({frame_byte[3:0], 2'b00});
              st.next_ofs = pos + ehhmp_pkg::OFS_W'({frame_byte[3:0], 2'b00})
                            + ehhmp_pkg::OFS_TCP_DOFF;
              st.phase = ehhmp_pkg::PH_TCP_DOFF;
            end
            ehhmp_pkg::PH_TCP_DOFF: begin
              st.next_ofs = ehhmp_pkg::ofs_max(
                st.tcp_ofs + ehhmp_pkg::OFS_W'({frame_byte[7:4], 2'b00}), pos);
              st.held = '0;
              st.match = ehhmp_pkg::MATCH_BOTH;
              st.phase = ehhmp_pkg::PH_METHOD;
            end
            ehhmp_pkg::PH_METHOD: begin
              idx = st.held[1:0];
              m = st.match;
              if (st.held >= 6'd3 || frame_byte != ehhmp_pkg::get_char(idx)) begin
                m = m & ~ehhmp_pkg::MATCH_GET;
              end
              if (st.held >= 6'd4 || frame_byte != ehhmp_pkg::post_char(idx)) begin
                m = m & ~ehhmp_pkg::MATCH_POST;
              end
              st.match = m;
              if (m[0] && st.held == 6'd2) begin
                hit = 1'b1;
                res_o.verdict = ehhmp_pkg::VD_GET;
                res_o.target_offset = pos[7:0] + 8'd2;
              end else if (m[1] && st.held == 6'd3) begin
                hit = 1'b1;
                res_o.verdict = ehhmp_pkg::VD_POST;
                res_o.target_offset = pos[7:0] + 8'd2;
              end else if (m == 2'b00) begin
                hit = 1'b1;
                res_o.verdict = ehhmp_pkg::VD_OTHER;
              end else begin
                st.held = st.held + 6'd1;
                st.next_ofs = pos + ehhmp_pkg::OFS_W'(1);
              end
            end
            default: begin
              st.phase = ehhmp_pkg::PH_DONE;
            end
          endcase
          if (hit) begin
            st.verdict_done = 1'b1;
            st.phase = ehhmp_pkg::PH_DONE;
          end
        end
      end

      if (!last) begin
        st.byte_count = st.byte_count + ehhmp_pkg::CNT_W'(1);
      end

      if (!hit && (frame_end || last)) begin
        hit = 1'b1;
        res_o.verdict = ehhmp_pkg::VD_TRUNCATED;
        res_o.target_offset = '0;
        st.verdict_done = 1'b1;
        st.phase = ehhmp_pkg::PH_DONE;
      end

      if (frame_end) begin
        st.phase = ehhmp_pkg::PH_IDLE;
      end
    end

    res_o.ip_offset = st.ip_ofs[7:0];
    res_o.tcp_offset = st.tcp_ofs[7:0];
    st_o = st;
    hit_o = hit;
  end

endmodule

// ===== tb/ehhmp_verdict_check.sv =====
`timescale 1ns / 1ps

module ehhmp_verdict_check (
  input  logic clk,
  input  logic rst_n,
  ehhmp_in_if  in_ch,
  ehhmp_out_if out_ch,
  output int   errors,
  output int   owed,
  output int   decided
);
  import ehhmp_pkg::*;

  localparam logic [23:0] GET_TEXT  = "GET";
  localparam logic [31:0] POST_TEXT = "POST";

  // header walk state, mirrored from the byte stream seen on in_ch
  phase_t      phase;
  int unsigned byte_pos;
  int unsigned next_ofs;
  int unsigned ip_ofs;
  int unsigned tcp_ofs;
  logic [7:0]  held;
  logic [1:0]  cand;

  walk_result_t verdict_due [$];
  walk_result_t fresh;

  function automatic void settle(input verdict_t v, input int unsigned target);
    fresh.verdict       = v;
    fresh.target_offset = target[7:0];
    fresh.ip_offset     = ip_ofs[7:0];
    fresh.tcp_offset    = tcp_ofs[7:0];
    phase               = PH_DONE;
  endfunction

  function automatic void open_ip(input int unsigned at);
    ip_ofs   = at;
    next_ofs = at;
    phase    = PH_IP_IHL;
  endfunction

  // Handle the field that starts at pos; return 1 once the verdict is known.
  function automatic bit walk_field(input logic [7:0] b, input int unsigned pos);
    int unsigned idx;
    case (phase)
      PH_ETH_HI: begin
        held     = b;
        next_ofs = OFS_ETH_TYPE_LO;
        phase    = PH_ETH_LO;
      end
      PH_ETH_LO: begin
        if (held == BYTE_ETH_IPV4_HI && b == BYTE_ETH_LO) begin
          open_ip(OFS_IP_PLAIN);
        end else if (held == BYTE_ETH_VLAN_HI && b == BYTE_ETH_LO) begin
          next_ofs = OFS_TAG_TYPE;
          phase    = PH_TAG_HI;
        end else begin
          settle(VD_BAD_ETH, 0);
          return 1'b1;
        end
      end
      PH_TAG_HI: begin
        held     = b;
        next_ofs = OFS_TAG_TYPE_LO;
        phase    = PH_TAG_LO;
      end
      PH_TAG_LO: begin
        if (held == BYTE_PPPOE_HI && b == BYTE_PPPOE_LO) begin
          open_ip(OFS_IP_PPPOE);
        end else if (held == BYTE_ETH_IPV4_HI && b == BYTE_ETH_LO) begin
          open_ip(OFS_IP_TAGGED);
        end else begin
          settle(VD_BAD_TAG, 0);
          return 1'b1;
        end
      end
      PH_IP_IHL: begin
        held     = {2'b00, b[3:0], 2'b00};
        next_ofs = ip_ofs + OFS_IP_PROTO;
        phase    = PH_IP_PROTO;
      end
      PH_IP_PROTO: begin
        if (b == BYTE_PROTO_UDP) begin
          next_ofs = ip_ofs + held + OFS_UDP_LEN;
          if (next_ofs < pos) next_ofs = pos;
          phase = PH_GTP;
        end else begin
          tcp_ofs  = ip_ofs + held;
          next_ofs = tcp_ofs + OFS_TCP_DOFF;
          phase    = PH_TCP_DOFF;
        end
      end
      PH_GTP: begin
        if (b == BYTE_GTP_SHORT) next_ofs = pos + OFS_GTP_SHORT;
        else if (b == BYTE_GTP_LONG) next_ofs = pos + OFS_GTP_LONG;
        else next_ofs = pos;
        phase = PH_INNER_IHL;
      end
      PH_INNER_IHL: begin
        ip_ofs   = pos;
        tcp_ofs  = pos + 4 * b[3:0];
        next_ofs = tcp_ofs + OFS_TCP_DOFF;
        phase    = PH_TCP_DOFF;
      end
      PH_TCP_DOFF: begin
        next_ofs = tcp_ofs + 4 * b[7:4];
        if (next_ofs < pos) next_ofs = pos;
        held  = 8'h00;
        cand  = MATCH_BOTH;
        phase = PH_METHOD;
      end
      PH_METHOD: begin
        idx = held;
        if (idx >= 3 || b != 8'(GET_TEXT >> (8 * (2 - idx)))) cand = cand & ~MATCH_GET;
        if (idx >= 4 || b != 8'(POST_TEXT >> (8 * (3 - idx)))) cand = cand & ~MATCH_POST;
        if ((cand & MATCH_GET) != 2'b00 && idx == 2) begin
          settle(VD_GET, pos + 2);
          return 1'b1;
        end
        if ((cand & MATCH_POST) != 2'b00 && idx == 3) begin
          settle(VD_POST, pos + 2);
          return 1'b1;
        end
        if (cand == 2'b00) begin
          settle(VD_OTHER, 0);
          return 1'b1;
        end
        held     = 8'(idx + 1);
        next_ofs = pos + 1;
      end
      default: phase = PH_DONE;
    endcase
    return 1'b0;
  endfunction

  // Advance the walk by one transferred byte; return 1 if it decides the frame.
  function automatic bit predict_byte(input logic [7:0] b, input bit first, input bit last);
    int unsigned pos;
    bit          hit;
    if (first) begin
      byte_pos = 0;
      next_ofs = OFS_ETH_TYPE;
      phase    = PH_ETH_HI;
      held     = 8'h00;
      ip_ofs   = 0;
      tcp_ofs  = 0;
      cand     = MATCH_BOTH;
    end
    if (phase == PH_IDLE) return 1'b0;
    if (phase == PH_DONE) begin
      if (last) phase = PH_IDLE;
      return 1'b0;
    end
    pos = byte_pos;
    hit = 1'b0;
    // several fields may start on the same byte
    while (!hit && phase != PH_DONE && pos == next_ofs) hit = walk_field(b, pos);
    if (byte_pos < FRAME_MAX_LEN) byte_pos++;
    if (!hit && (last || byte_pos >= FRAME_MAX_LEN)) begin
      settle(VD_TRUNCATED, 0);
      hit = 1'b1;
    end
    if (last) phase = PH_IDLE;
    return hit;
  endfunction

  always @(posedge clk) begin
    walk_result_t want;
    if (!rst_n) begin
      phase    = PH_IDLE;
      byte_pos = 0;
      next_ofs = 0;
      ip_ofs   = 0;
      tcp_ofs  = 0;
      held     = 8'h00;
      cand     = MATCH_BOTH;
      verdict_due.delete();
      errors   = 0;
      owed     = 0;
      decided  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_due.size() == 0) begin
          $error("verdict %0d transferred with none expected", out_ch.verdict);
          errors++;
        end else begin
          want = verdict_due.pop_front();
          if (out_ch.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_ch.verdict);
            errors++;
          end
          if (out_ch.target_offset !== want.target_offset) begin
            $error("target_offset: expected %0d, got %0d",
                   want.target_offset, out_ch.target_offset);
            errors++;
          end
          if (out_ch.ip_offset !== want.ip_offset) begin
            $error("ip_offset: expected %0d, got %0d", want.ip_offset, out_ch.ip_offset);
            errors++;
          end
          if (out_ch.tcp_offset !== want.tcp_offset) begin
            $error("tcp_offset: expected %0d, got %0d", want.tcp_offset, out_ch.tcp_offset);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_byte(in_ch.frame_byte, in_ch.frame_start, in_ch.frame_end)) begin
          verdict_due.push_back(fresh);
          decided++;
        end
      end
      owed = verdict_due.size();
    end
  end

endmodule

// ===== tb/tb_encap_header_http_method_parser.sv =====
`timescale 1ns / 1ps

module tb_encap_header_http_method_parser;
  import ehhmp_pkg::*;

  localparam int          BUF_LEN       = 320;
  localparam int          VERDICTS_GOAL = 30;

  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic [31:0] WORD_GET  = "GET ";
  localparam logic [31:0] WORD_POST = "POST";

  typedef enum {ENC_PLAIN, ENC_VLAN, ENC_PPPOE, ENC_BAD_ETH, ENC_BAD_TAG} encap_t;
  typedef enum {REQ_GET, REQ_POST, REQ_OTHER} request_t;

  logic        clk;
  logic        rst_n;
  bit          steady;       // hold both sides free of idle cycles
  int          errors;
  int          owed;
  int          decided;

  // frame under construction; pinned marks bytes the walk has already claimed
  logic [7:0] frame_buf [0:BUF_LEN-1];
  bit         pinned    [0:BUF_LEN-1];

  ehhmp_in_if  in_ch ();
  ehhmp_out_if out_ch ();

  encap_header_http_method_parser uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ehhmp_verdict_check verdict_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .owed   (owed),
    .decided(decided)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side about one cycle in ten, except in the steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Place a field byte unless an earlier field already sits there; return what
  // the walker will actually see at that offset.
  function automatic logic [7:0] pin(input int unsigned at, input logic [7:0] val);
    if (at >= BUF_LEN) return val;
    if (!pinned[at]) begin
      frame_buf[at] = val;
      pinned[at]    = 1'b1;
    end
    return frame_buf[at];
  endfunction

  // Fill frame_buf with random content and lay the header fields where the
  // walker will look for them. full_len covers the method or bad type plus a short tail.
  task automatic build_frame(input encap_t enc, input int unsigned ihl, input bit udp,
                             input logic [7:0] gtp_byte, input int unsigned inner_ihl,
                             input int unsigned doff, input request_t req,
                             output int unsigned full_len);
    int unsigned ip;
    int unsigned tcp;
    int unsigned gtp_at;
    int unsigned inner;
    int unsigned mstart;
    logic [7:0]  hi;
    logic [7:0]  v;
    logic [31:0] word;
    for (int i = 0; i < BUF_LEN; i++) begin
      frame_buf[i] = 8'($urandom);
      pinned[i]    = 1'b0;
    end
    case ($urandom_range(0, 3))
      0:       hi = BYTE_ETH_IPV4_HI;
      1:       hi = BYTE_ETH_VLAN_HI;
      2:       hi = BYTE_PPPOE_HI;
      default: hi = 8'($urandom);
    endcase
    v = 8'($urandom);
    case (enc)
      ENC_PLAIN: begin
        void'(pin(12, BYTE_ETH_IPV4_HI));
        void'(pin(13, BYTE_ETH_LO));
        ip = OFS_IP_PLAIN;
      end
      ENC_VLAN, ENC_PPPOE: begin
        void'(pin(12, BYTE_ETH_VLAN_HI));
        void'(pin(13, BYTE_ETH_LO));
        void'(pin(16, (enc == ENC_VLAN) ? BYTE_ETH_IPV4_HI : BYTE_PPPOE_HI));
        void'(pin(17, (enc == ENC_VLAN) ? BYTE_ETH_LO : BYTE_PPPOE_LO));
        ip = (enc == ENC_VLAN) ? OFS_IP_TAGGED : OFS_IP_PPPOE;
      end
      ENC_BAD_ETH: begin
        // keep near misses of the two accepted types
        if ((hi == BYTE_ETH_IPV4_HI || hi == BYTE_ETH_VLAN_HI) && v == BYTE_ETH_LO)
          v = v ^ 8'h01;
        void'(pin(12, hi));
        void'(pin(13, v));
        full_len = 14 + $urandom_range(0, 8);
        return;
      end
      default: begin
        if ((hi == BYTE_PPPOE_HI && v == BYTE_PPPOE_LO) ||
            (hi == BYTE_ETH_IPV4_HI && v == BYTE_ETH_LO))
          v = v ^ 8'h01;
        void'(pin(12, BYTE_ETH_VLAN_HI));
        void'(pin(13, BYTE_ETH_LO));
        void'(pin(16, hi));
        void'(pin(17, v));
        full_len = 18 + $urandom_range(0, 8);
        return;
      end
    endcase

    v  = pin(ip, {4'($urandom), ihl[3:0]});
    hi = 8'($urandom);
    if (hi == BYTE_PROTO_UDP || $urandom_range(0, 3) != 0) hi = PROTO_TCP;
    if (pin(ip + OFS_IP_PROTO, udp ? BYTE_PROTO_UDP : hi) == BYTE_PROTO_UDP) begin
      // a header start already passed is taken at the protocol byte itself
      gtp_at = ip + 4 * v[3:0] + OFS_UDP_LEN;
      if (gtp_at < ip + OFS_IP_PROTO) gtp_at = ip + OFS_IP_PROTO;
      hi = pin(gtp_at, gtp_byte);
      if (hi == BYTE_GTP_SHORT) inner = gtp_at + OFS_GTP_SHORT;
      else if (hi == BYTE_GTP_LONG) inner = gtp_at + OFS_GTP_LONG;
      else inner = gtp_at;
      v   = pin(inner, {4'($urandom), inner_ihl[3:0]});
      tcp = inner + 4 * v[3:0];
    end else begin
      tcp = ip + 4 * v[3:0];
    end
    v      = pin(tcp + OFS_TCP_DOFF, {doff[3:0], 4'($urandom)});
    mstart = tcp + 4 * v[7:4];
    if (mstart < tcp + OFS_TCP_DOFF) mstart = tcp + OFS_TCP_DOFF;

    case (req)
      REQ_GET:  word = WORD_GET;
      REQ_POST: word = WORD_POST;
      default: begin
        case ($urandom_range(0, 4))
          0:       word = "PUT ";
          1:       word = "GEE ";
          2:       word = "POSE";
          3:       word = "HEAD";
          default: word = $urandom;
        endcase
      end
    endcase
    for (int i = 0; i < 4; i++) void'(pin(mstart + i, word[31 - 8 * i -: 8]));
    full_len = mstart + 4 + $urandom_range(0, 12);
  endtask

  // Present one byte from the falling edge and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b, input bit first, input bit last);
    if (!steady && $urandom_range(0, 99) < 5) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frame_byte  <= b;
    in_ch.frame_start <= first;
    in_ch.frame_end   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Send the first len bytes of frame_buf; leave the frame open unless closed.
  task automatic send_frame(input int unsigned len, input bit closed);
    for (int unsigned i = 0; i < len; i++)
      push_byte((i < BUF_LEN) ? frame_buf[i] : 8'($urandom), i == 0, closed && i == len - 1);
  endtask

  // Drop valid and wait until every verdict owed has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
  endtask

  initial begin
    int unsigned len;
    int unsigned frame_no;
    int unsigned n;
    encap_t      enc;
    request_t    req;
    logic [7:0]  flag;
    bit          closed;

    rst_n             = 1'b0;
    steady            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.frame_byte  = 8'h00;
    in_ch.frame_start = 1'b0;
    in_ch.frame_end   = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plain path with both methods, tagged path with GET
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(len, 1'b1);
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_POST, len);
    send_frame(len, 1'b1);
    build_frame(ENC_VLAN, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(len, 1'b1);
    // widest IPv4 and TCP headers
    build_frame(ENC_PPPOE, 15, 1'b0, 8'h00, 0, 15, REQ_POST, len);
    send_frame(len, 1'b1);
    // deepest walk: PPPoE, long GTP header, widest inner and TCP headers
    build_frame(ENC_PPPOE, 15, 1'b1, BYTE_GTP_LONG, 15, 15, REQ_POST, len);
    send_frame(len, 1'b1);
    build_frame(ENC_PLAIN, 5, 1'b1, BYTE_GTP_SHORT, 5, 5, REQ_GET, len);
    send_frame(len, 1'b1);
    // unknown GTP flag: inner header starts on the flag byte
    build_frame(ENC_VLAN, 5, 1'b1, 8'h7F, 5, 5, REQ_GET, len);
    send_frame(len, 1'b1);
    // UDP behind a zero IHL: GTP field lands on the protocol byte
    build_frame(ENC_PLAIN, 0, 1'b1, BYTE_GTP_SHORT, 5, 5, REQ_POST, len);
    send_frame(len, 1'b1);
    // doff below four: method starts on the doff byte
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 0, REQ_GET, len);
    send_frame(len, 1'b1);
    build_frame(ENC_PLAIN, 0, 1'b0, 8'h00, 0, 3, REQ_POST, len);
    send_frame(len, 1'b1);
    // rejects: ethertype, tagged type, method; decide on the last byte too
    build_frame(ENC_BAD_ETH, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(14, 1'b1);
    build_frame(ENC_BAD_TAG, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(len, 1'b1);
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_OTHER, len);
    send_frame(len, 1'b1);
    // early end, in the IPv4 header and right after the tag
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(20, 1'b1);
    build_frame(ENC_VLAN, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(18, 1'b1);
    // start and end on one byte
    push_byte(8'hFF, 1'b1, 1'b1);
    // idle bytes outside any frame, one carrying frame_end
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    // abandon an open frame with a new start
    build_frame(ENC_PPPOE, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(30, 1'b0);
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_POST, len);
    send_frame(len, 1'b1);
    // a long run of bytes after the verdict, up to the frame end
    build_frame(ENC_PLAIN, 5, 1'b0, 8'h00, 0, 5, REQ_GET, len);
    send_frame(len + 40, 1'b1);

    drain();

    // Random part: mostly well-formed walks with random content, the rest
    // idle bytes, one-byte frames and garbage. A run of frames in the middle
    // goes without idle cycles on either side.
    frame_no = 0;
    while (decided < VERDICTS_GOAL) begin
      steady = (frame_no >= 3 && frame_no < 9);
      n = $urandom_range(0, 99);
      if (n < 70) begin
        case ($urandom_range(0, 9))
          0, 1, 2: enc = ENC_PLAIN;
          3, 4:    enc = ENC_VLAN;
          5, 6:    enc = ENC_PPPOE;
          7:       enc = ENC_BAD_ETH;
          default: enc = ENC_BAD_TAG;
        endcase
        n = $urandom_range(0, 99);
        if (n < 40) flag = BYTE_GTP_SHORT;
        else if (n < 80) flag = BYTE_GTP_LONG;
        else flag = 8'($urandom);
        n = $urandom_range(0, 99);
        if (n < 40) req = REQ_GET;
        else if (n < 80) req = REQ_POST;
        else req = REQ_OTHER;
        build_frame(enc,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5,
                    $urandom_range(0, 99) < 40, flag,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5,
                    req, len);
        if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len - 1);
        closed = ($urandom_range(0, 99) >= 8);
        send_frame(len, closed);
      end else if (n < 80) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, 1'($urandom));
      end else if (n < 88) begin
        push_byte(8'($urandom), 1'b1, 1'b1);
      end else begin
        n = $urandom_range(1, 40);
        for (int unsigned i = 0; i < n; i++)
          push_byte(8'($urandom), i == 0, i == n - 1);
      end
      if ($urandom_range(0, 99) < 5) drain();
      frame_no++;
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    while (owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && owed == 0) begin
      $display("tb_encap_header_http_method_parser: PASS");
    end else begin
      $display("tb_encap_header_http_method_parser: FAIL");
    end
    $finish;
  end

  // Bound the run well above the slowest legal schedule.
  initial begin
    #5_000_000;
    $display("tb_encap_header_http_method_parser: FAIL");
    $finish;
  end

endmodule
